// File: hw/rtl/wmf_pkg.sv
`default_nettype none

package wmf_pkg;

   // Default sizes of the window and of the image.
   localparam int MAX_WINDOW_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // The median is element (k*k)/MEDIAN_DIV of the sorted window.
   localparam int MEDIAN_DIV = 2;

   // Port and field widths, and the configuration reset values.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = NUM_CHAN * CHAN_W;
   localparam int BIT_IDX_W  = $clog2(CHAN_W);
   localparam int ANCHOR_W   = 10;

   localparam logic [2:0]            WINDOW_SIZE_RST  = 3'd3;
   localparam logic [CSR_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_SIZE  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } csr_reg_type;

   // One input word: a three-channel pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [CHAN_W-1:0]   median_a;
      logic [CHAN_W-1:0]   median_b;
      logic [CHAN_W-1:0]   median_c;
      logic [ANCHOR_W-1:0] anchor_row;
      logic [ANCHOR_W-1:0] anchor_col;
      logic                frame_end;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 accept;
      logic                 load;
      logic                 count;
      logic                 decide;
      logic                 out_load;
      logic [BIT_IDX_W-1:0] bit_idx;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/wmf_ctrl.sv
`default_nettype none

module wmf_ctrl import wmf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOAD   = 5'b00010,
      S_COUNT  = 5'b00100,
      S_DECIDE = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.bit_idx  = bit_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            bit_in   = BIT_IDX_W'(CHAN_W - 1);
            state_in = status.emit ? S_COUNT : S_IDLE;
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (bit_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_COUNT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

   // A result word is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a word still waiting");

   // An accepted word is always moved into the window on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_LOAD)
      else $error("accepted word not loaded");

   // The last bit decision always leads to emitting the result.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && bit_ff == '0) |=> state_ff == S_EMIT)
      else $error("selection ended without a result");

endmodule

`default_nettype wire

// File: hw/rtl/wmf_datapath.sv
`default_nettype none

module wmf_datapath import wmf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire req_type               req_data,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_status_type            status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data
);

   localparam int MW     = MAX_WINDOW;
   localparam int LR     = (MW > 1) ? MW - 1 : 1;
   localparam int BK_W   = (LR > 1) ? $clog2(LR) : 1;
   localparam int KW     = $clog2(MW + 1);
   localparam int KC_W   = (KW > 3) ? KW : 3;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WC_W   = (WID_W > CSR_DATA_W) ? WID_W : CSR_DATA_W;
   localparam int HC_W   = (HGT_W > CSR_DATA_W) ? HGT_W : CSR_DATA_W;
   localparam int CW     = $clog2(MW + 1);
   localparam int TOTW   = $clog2(MW * MW + 1);
   localparam int TW     = $clog2(3 * LR + MW + 2);

   // Configuration registers.
   logic [2:0]            wsize_ff;
   logic [CSR_DATA_W-1:0] width_ff, height_ff;

   // Raster position of the next pixel and the line bank of its row.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [BK_W-1:0]  bank_ff;

   // Values captured with an accepted word.
   logic [PIX_W-1:0]    pix_ff;
   logic [BK_W-1:0]     base_ff;
   logic                emit_ff, last_ff;
   logic [ANCHOR_W-1:0] arow_ff, acol_ff;

   // Line buffers, their read data and the window.
   logic [PIX_W-1:0] line_mem [LR][MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff [LR];
   logic [PIX_W-1:0] win_ff [MW][MW];
   logic [PIX_W-1:0] newcol [MW];

   // Selection state, one set per channel.
   logic              cand_ff [NUM_CHAN][MW][MW];
   logic [TOTW-1:0]   rank_ff [NUM_CHAN];
   logic [CW-1:0]     ccnt_ff [NUM_CHAN][MW];
   logic [CW-1:0]     ccnt_in [NUM_CHAN][MW];
   logic [TOTW-1:0]   total   [NUM_CHAN];
   logic [CHAN_W-1:0] med_ff  [NUM_CHAN];

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   // Effective window and image sizes after clamping.
   logic [KW-1:0]    k_eff;
   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [KC_W-1:0]  k_raw;
   logic [WC_W-1:0]  w_raw;
   logic [HC_W-1:0]  h_raw;
   logic [TOTW-1:0]  rank_init;

   always_comb begin
      k_raw = KC_W'(wsize_ff);
      w_raw = WC_W'(width_ff);
      h_raw = HC_W'(height_ff);
      if (k_raw == '0) begin
         k_eff = KW'(1);
      end else if (k_raw > KC_W'(MW)) begin
         k_eff = KW'(MW);
      end else begin
         k_eff = KW'(k_raw);
      end
      if (w_raw == '0) begin
         w_eff = WID_W'(1);
      end else if (w_raw > WC_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(w_raw);
      end
      if (h_raw == '0) begin
         h_eff = HGT_W'(1);
      end else if (h_raw > HC_W'(MAX_HEIGHT)) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HGT_W'(h_raw);
      end
      rank_init = TOTW'(((2 * KW)'(k_eff) * (2 * KW)'(k_eff)) / MEDIAN_DIV);
   end

   // Position logic for the word at the current position.
   logic [WID_W-1:0] col_next;
   logic [HGT_W-1:0] row_next;
   logic             csr_hit;

   assign col_next = WID_W'(col_ff) + 1'b1;
   assign row_next = HGT_W'(row_ff) + 1'b1;
   assign csr_hit  = csr_valid && (csr_index == REG_WINDOW_SIZE ||
                     csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT);

   // Configuration writes and the raster counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff  <= WINDOW_SIZE_RST;
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         bank_ff   <= '0;
      end else if (csr_hit) begin
         unique case (csr_index)
            REG_WINDOW_SIZE:  wsize_ff  <= csr_data[2:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default:          wsize_ff  <= wsize_ff;
         endcase
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= '0;
      end else if (cmd.accept) begin
         if (col_next >= w_eff) begin
            col_ff <= '0;
            if (row_next >= h_eff) begin
               row_ff  <= '0;
               bank_ff <= '0;
            end else begin
               row_ff  <= ROW_W'(row_next);
               bank_ff <= (bank_ff == BK_W'(LR - 1)) ? '0 : bank_ff + 1'b1;
            end
         end else begin
            col_ff <= COL_W'(col_next);
         end
      end
   end

   // Capture the word, its anchor, whether it closes a full window and whether it ends the frame.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff  <= {req_data.chan_c, req_data.chan_b, req_data.chan_a};
         base_ff <= bank_ff;
         emit_ff <= (row_next >= HGT_W'(k_eff)) && (col_next >= WID_W'(k_eff));
         last_ff <= (row_next == h_eff) && (col_next == w_eff);
         arow_ff <= ANCHOR_W'(row_ff - ROW_W'(k_eff - 1'b1));
         acol_ff <= ANCHOR_W'(col_ff - COL_W'(k_eff - 1'b1));
      end
   end

   // Line buffers: the current row is written while the older rows are read.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         line_mem[bank_ff][col_ff] <= {req_data.chan_c, req_data.chan_b, req_data.chan_a};
         for (int i = 0; i < LR; i++) begin
            rd_ff[i] <= line_mem[i][col_ff];
         end
      end
   end

   // New window column: older rows from their banks, the current row last.
   always_comb begin
      logic [TW-1:0] t;
      for (int y = 0; y < MW; y++) begin
         t = TW'(base_ff) + TW'(y) + TW'(LR + 1) - TW'(k_eff);
         if (t >= TW'(LR)) begin
            t = t - TW'(LR);
         end
         if (t >= TW'(LR)) begin
            t = t - TW'(LR);
         end
         if (y < LR && KW'(y) != k_eff - 1'b1) begin
            newcol[y] = rd_ff[BK_W'(t)];
         end else begin
            newcol[y] = pix_ff;
         end
      end
   end

   // Window shift: older columns move down, the new one enters at k-1.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int x = 0; x < MW; x++) begin
            if (KW'(x) == k_eff - 1'b1) begin
               win_ff[x] <= newcol;
            end else if (KW'(x) < k_eff - 1'b1 && x < MW - 1) begin
               win_ff[x] <= win_ff[x + 1];
            end
         end
      end
   end

   // Per column count of candidates whose current bit is zero, then the total.
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         total[ch] = '0;
         for (int x = 0; x < MW; x++) begin
            ccnt_in[ch][x] = '0;
            for (int y = 0; y < MW; y++) begin
               ccnt_in[ch][x] = ccnt_in[ch][x] + CW'(cand_ff[ch][x][y] &&
                                !win_ff[x][y][ch * CHAN_W + int'(cmd.bit_idx)]);
            end
            total[ch] = total[ch] + TOTW'(ccnt_ff[ch][x]);
         end
      end
   end

   // Bitwise median search, most significant bit first.
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         if (cmd.load) begin
            rank_ff[ch] <= rank_init;
            for (int x = 0; x < MW; x++) begin
               for (int y = 0; y < MW; y++) begin
                  cand_ff[ch][x][y] <= (KW'(x) < k_eff) && (KW'(y) < k_eff);
               end
            end
         end else if (cmd.count) begin
            ccnt_ff[ch] <= ccnt_in[ch];
         end else if (cmd.decide) begin
            if (rank_ff[ch] < total[ch]) begin
               med_ff[ch][cmd.bit_idx] <= 1'b0;
               for (int x = 0; x < MW; x++) begin
                  for (int y = 0; y < MW; y++) begin
                     cand_ff[ch][x][y] <= cand_ff[ch][x][y] &&
                        !win_ff[x][y][ch * CHAN_W + int'(cmd.bit_idx)];
                  end
               end
            end else begin
               med_ff[ch][cmd.bit_idx] <= 1'b1;
               rank_ff[ch] <= rank_ff[ch] - total[ch];
               for (int x = 0; x < MW; x++) begin
                  for (int y = 0; y < MW; y++) begin
                     cand_ff[ch][x][y] <= cand_ff[ch][x][y] &&
                        win_ff[x][y][ch * CHAN_W + int'(cmd.bit_idx)];
                  end
               end
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.median_a   <= med_ff[0];
         rsp_data_ff.median_b   <= med_ff[1];
         rsp_data_ff.median_c   <= med_ff[2];
         rsp_data_ff.anchor_row <= arow_ff;
         rsp_data_ff.anchor_col <= acol_ff;
         rsp_data_ff.frame_end  <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.emit     = emit_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// File: hw/rtl/window_median_filter_3ch.sv
// Each word accepted in idle is loaded into the window; a word that completes a full
// window then runs the bitwise median search (count and decide for each of 8 bits)
// and waits in emit until the output register is free; any other word returns to idle.
// No new word is taken before the block is through with the last one.
// Reset (synchronous, active high) restores the register defaults and the raster
// position; the line buffers and window hold no reset value and need no clearing.
`default_nettype none

module window_median_filter_3ch import wmf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   wmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wmf_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: bench/window_median_filter_3ch_test.sv
`timescale 1ns / 100ps

module window_median_filter_3ch_test;
   import wmf_pkg::*;

   localparam int LINE_ROWS   = MAX_WINDOW_DEF - 1;
   localparam int SETTLE      = 25;
   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;

   // Predictor state: configuration, raster position, line buffers and window.
   logic [2:0]            cfg_window;
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;
   int                    row_pos;
   int                    col_pos;
   logic [PIX_W-1:0]      line_mem [LINE_ROWS][MAX_WIDTH_DEF];
   logic [PIX_W-1:0]      win_mem [MAX_WINDOW_DEF][MAX_WINDOW_DEF];

   rsp_type median_want_q [$];
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      hold_request = 0;
   int      hold_left = 0;
   int      mismatch_count = 0;
   int      pixels_sent = 0;
   int      results_seen = 0;
   int      frame_ends_seen = 0;
   int      reg_writes = 0;
   longint  cycle_count = 0;

   window_median_filter_3ch uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  median_want_q.size());
         $display("window_median_filter_3ch verification failed");
         $finish;
      end
   end

   function automatic int clamp_size(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Median of one channel over the k-by-k window, upper median for even k.
   function automatic logic [CHAN_W-1:0] window_median(int k, int shift);
      logic [CHAN_W-1:0] vals [MAX_WINDOW_DEF*MAX_WINDOW_DEF];
      logic [CHAN_W-1:0] v;
      int n, i, j;
      n = 0;
      for (int x = 0; x < k; x++) begin
         for (int y = 0; y < k; y++) begin
            vals[n] = win_mem[x][y][shift +: CHAN_W];
            n++;
         end
      end
      for (i = 1; i < n; i++) begin
         v = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = v;
      end
      return vals[n / MEDIAN_DIV];
   endfunction

   // Advance the predictor by one accepted pixel and queue any result it completes.
   function automatic void predict_pixel(req_type p);
      int k, w, h, r, c;
      logic [PIX_W-1:0] pix;
      rsp_type res;
      k = clamp_size(cfg_window, MAX_WINDOW_DEF);
      w = clamp_size(cfg_width, MAX_WIDTH_DEF);
      h = clamp_size(cfg_height, MAX_HEIGHT_DEF);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      pix = {p.chan_c, p.chan_b, p.chan_a};
      for (int x = 0; x + 1 < k; x++)
         for (int y = 0; y < k; y++)
            win_mem[x][y] = win_mem[x+1][y];
      for (int y = 0; y + 1 < k; y++) begin
         if (r + y + 1 >= k)
            win_mem[k-1][y] = line_mem[(r + y + 1 - k) % LINE_ROWS][c];
         else
            win_mem[k-1][y] = '0;
      end
      win_mem[k-1][k-1] = pix;
      line_mem[r % LINE_ROWS][c] = pix;
      if (r + 1 >= k && c + 1 >= k) begin
         res.median_a   = window_median(k, 0);
         res.median_b   = window_median(k, CHAN_W);
         res.median_c   = window_median(k, 2 * CHAN_W);
         res.anchor_row = ANCHOR_W'(r + 1 - k);
         res.anchor_col = ANCHOR_W'(c + 1 - k);
         res.frame_end  = (r + 1 == h && c + 1 == w);
         median_want_q.insert(median_want_q.size(), res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   // Result side: random stalls, long hold-offs on request, and the check of each word.
   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.frame_end) frame_ends_seen++;
         if (median_want_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word %p", rsp_data);
         end else begin
            want = median_want_q.pop_front();
            if (rsp_data.median_a !== want.median_a || rsp_data.median_b !== want.median_b ||
                rsp_data.median_c !== want.median_c ||
                rsp_data.anchor_row !== want.anchor_row ||
                rsp_data.anchor_col !== want.anchor_col ||
                rsp_data.frame_end !== want.frame_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at cycle %0d: expected %p, got %p", cycle_count,
                           want, rsp_data);
            end
         end
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one pixel word, with an optional idle gap first, and wait for acceptance.
   task automatic send_pixel(req_type p);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      predict_pixel(p);
      pixels_sent++;
   endtask

   // Lower valid and wait until every expected result has come, plus settling time.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (median_want_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one register once the block is idle.
   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_WINDOW_SIZE:  cfg_window = value[2:0];
         REG_IMAGE_WIDTH:  cfg_width  = value;
         REG_IMAGE_HEIGHT: cfg_height = value;
         default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
      reg_writes++;
   endtask

   // Random pixel: full range, narrow range for ties, or channel extremes.
   function automatic req_type random_pixel();
      req_type p;
      case ($urandom_range(3))
         0: begin
            p.chan_a = 8'($urandom_range(120, 123));
            p.chan_b = 8'($urandom_range(0, 2));
            p.chan_c = 8'($urandom_range(253, 255));
         end
         1: begin
            p.chan_a = $urandom_range(1) ? 8'hff : 8'h00;
            p.chan_b = $urandom_range(1) ? 8'hff : 8'h00;
            p.chan_c = $urandom_range(1) ? 8'hff : 8'h00;
         end
         default: p = req_type'(PIX_W'($urandom));
      endcase
      return p;
   endfunction

   task automatic set_image(int k, int w, int h);
      write_reg(REG_WINDOW_SIZE, CSR_DATA_W'(k));
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic send_pixels(int n);
      for (int i = 0; i < n; i++) send_pixel(random_pixel());
   endtask

   // Reset defaults, window sizes zero, one, even and maximum, degenerate and oversized images.
   task automatic test_directed();
      send_pixel('0);
      send_pixel('1);
      send_pixel(req_type'(24'h00ff00));
      set_image(0, 2, 2);
      send_pixel('0);
      send_pixel('1);
      send_pixel(req_type'(24'hff00ff));
      send_pixel(req_type'(24'h0f80f0));
      set_image(7, 0, 0);
      send_pixel('1);
      send_pixel('0);
      set_image(2, 3, 3);
      send_pixels(9);
      set_image(1, 2047, 2047);
      send_pixels(3);
   endtask

   // Random images and window sizes, whole frames with occasional partial ones.
   task automatic test_random_frames(int quota, int idle_pct, int stall_pct);
      int k, w, h, start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = pixels_sent;
      while (pixels_sent - start < quota) begin
         k = $urandom_range(0, 7);
         if ($urandom_range(9) == 0) begin
            w = $urandom_range(0, 6);
            h = $urandom_range(0, 6);
         end else begin
            w = clamp_size(k, 7) + $urandom_range(0, 7);
            h = clamp_size(k, 7) + $urandom_range(0, 5);
         end
         case ($urandom_range(3))
            0: write_reg(REG_WINDOW_SIZE, CSR_DATA_W'(k));
            1: begin
               write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
               write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
               write_reg(REG_WINDOW_SIZE, CSR_DATA_W'(k));
            end
            default: set_image(k, w, h);
         endcase
         w = clamp_size(cfg_width, MAX_WIDTH_DEF);
         h = clamp_size(cfg_height, MAX_HEIGHT_DEF);
         if (w * h <= 150)
            send_pixels(w * h * $urandom_range(1, 2) + $urandom_range(0, w));
         else
            send_pixels($urandom_range(20, 80));
      end
   endtask

   // Long receiver hold-off so the block backs up, then a pause until all results arrive.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_image(3, 8, 6);
      hold_request = 600;
      send_pixels(48);
      wait_drain();
      set_image(7, 9, 8);
      hold_request = 900;
      send_pixels(72);
      wait_drain();
   endtask

   initial begin
      cfg_window = WINDOW_SIZE_RST;
      cfg_width  = IMAGE_WIDTH_RST;
      cfg_height = IMAGE_HEIGHT_RST;
      row_pos = 0;
      col_pos = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_frames(300, 0, 0);
      test_random_frames(300, 59, 0);
      test_random_frames(300, 0, 59);
      test_random_frames(300, 26, 26);
      test_backpressure();
      test_random_frames(100, 26, 26);

      wait_drain();
      $display("%0d pixel words, %0d result words (%0d frame ends), %0d register writes",
               pixels_sent, results_seen, frame_ends_seen, reg_writes);
      $display("window sizes 0 to 7, image sizes 0 up to saturation, idle and stall phases");
      if (mismatch_count == 0 && median_want_q.size() == 0) begin
         $display("window_median_filter_3ch verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  median_want_q.size());
         $display("window_median_filter_3ch verification failed");
      end
      $finish;
   end

endmodule

// File: window_median_filter_3ch.f
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_ctrl.sv
hw/rtl/wmf_datapath.sv
hw/rtl/window_median_filter_3ch.sv
bench/window_median_filter_3ch_test.sv
